### hdl/krms_pkg.sv
// Shared types, state codes and byte constants for the key record marker scanner.
`timescale 1ns / 1ps
`default_nettype none
package krms_pkg;

  localparam int HIST_LEN = 64;
  localparam int ST_W     = 5;
  localparam int KIND_W   = 3;
  localparam int BACK_W   = 6;
  localparam int SEEN_W   = 7;

  // window for the 00 00 00 20 search, distance of its first byte back
  localparam int WIN_HI   = 64;
  localparam int WIN_LO   = 38;
  localparam int WIN_N    = WIN_HI - WIN_LO + 1;
  localparam int BACK_MIN = WIN_LO - 4;
  localparam int BACK_MAX = WIN_HI - 4;

  typedef logic [7:0]               byte_t;
  typedef logic [ST_W-1:0]          state_t;
  typedef logic [KIND_W-1:0]        kind_t;
  typedef logic [BACK_W-1:0]        back_t;
  typedef logic [HIST_LEN-1:0][7:0] hist_t;

  // result kinds
  localparam kind_t KIND_NONE        = 3'd0;
  localparam kind_t KIND_TAG_PUB     = 3'd1;
  localparam kind_t KIND_TAG_CMP     = 3'd2;
  localparam kind_t KIND_BITS_PUB    = 3'd3;
  localparam kind_t KIND_PRIV_PREFIX = 3'd4;
  localparam kind_t KIND_JAVA_PRIV   = 3'd5;
  localparam kind_t KIND_JAVA_NOPRIV = 3'd6;

  // scanner states
  localparam state_t ST_IDLE     = 5'd0;
  localparam state_t ST_01       = 5'd1;
  localparam state_t ST_0103     = 5'd2;
  localparam state_t ST_KEY_K    = 5'd3;
  localparam state_t ST_KEY_E    = 5'd4;
  localparam state_t ST_KEY_Y    = 5'd5;
  localparam state_t ST_HIT_PUB  = 5'd6;
  localparam state_t ST_HIT_CMP  = 5'd7;
  localparam state_t ST_0101     = 5'd8;
  localparam state_t ST_010104   = 5'd9;
  localparam state_t ST_HIT_PRIV = 5'd10;
  localparam state_t ST_03       = 5'd11;
  localparam state_t ST_0342     = 5'd12;
  localparam state_t ST_HIT_BITS = 5'd13;
  localparam state_t ST_SPARE    = 5'd14;
  localparam state_t ST_Z1       = 5'd15;
  localparam state_t ST_Z2       = 5'd16;
  localparam state_t ST_Z3       = 5'd17;
  localparam state_t ST_Z3_41    = 5'd18;
  localparam state_t ST_HIT_JAVA = 5'd19;
  localparam state_t ST_LAST     = ST_HIT_JAVA;

  // marker bytes
  localparam byte_t B_00 = 8'h00;
  localparam byte_t B_01 = 8'h01;
  localparam byte_t B_03 = 8'h03;
  localparam byte_t B_04 = 8'h04;
  localparam byte_t B_20 = 8'h20;
  localparam byte_t B_21 = 8'h21;
  localparam byte_t B_41 = 8'h41;
  localparam byte_t B_42 = 8'h42;
  localparam byte_t B_65 = 8'h65;
  localparam byte_t B_6B = 8'h6b;
  localparam byte_t B_79 = 8'h79;

  // scanner step as seen by the top level
  typedef struct packed {
    state_t state_nxt;
    logic   java_hit;
    kind_t  kind;
  } fsm_out_t;

endpackage
`default_nettype wire

### hdl/krms_if.sv
// Valid/ready channel interfaces for scanner input bytes and results.
`timescale 1ns / 1ps
`default_nettype none
interface krms_in_if;
  logic             valid;
  logic             ready;
  krms_pkg::byte_t  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface krms_out_if;
  logic             valid;
  logic             ready;
  krms_pkg::kind_t  match_kind;
  krms_pkg::back_t  priv_back;

  modport source (output valid, output match_kind, output priv_back, input ready);
  modport sink   (input valid, input match_kind, input priv_back, output ready);
endinterface
`default_nettype wire

### hdl/krms_fsm.sv
// Marker transition table: next state and marker kind for one byte.
`timescale 1ns / 1ps
`default_nettype none
module krms_fsm (
  input  wire krms_pkg::state_t   state,
  input  wire krms_pkg::byte_t    data_byte,
  output krms_pkg::fsm_out_t      fsm_out
);
  import krms_pkg::*;

  state_t zero_tgt;
  state_t nxt;

  // where a 00 byte leads; runs of zeros feed the java marker
  always_comb begin
    case (state)
      ST_0342:            zero_tgt = ST_HIT_BITS;
      ST_HIT_BITS, ST_Z1: zero_tgt = ST_Z2;
      ST_Z2, ST_Z3:       zero_tgt = ST_Z3;
      default:            zero_tgt = ST_Z1;
    endcase
  end

  // bytes listed in a row are distinct, so match order does not matter
  always_comb begin
    nxt = ST_IDLE;
    if (data_byte == B_00) begin
      nxt = zero_tgt;
    end else if (data_byte == B_01) begin
      nxt = (state == ST_01 || state == ST_0101) ? ST_0101 : ST_01;
    end else if (data_byte == B_03) begin
      nxt = (state == ST_01 || state == ST_0101) ? ST_0103 : ST_03;
    end
    case (state)
      ST_0103: begin
        if (data_byte == B_6B) nxt = ST_KEY_K;
        if (data_byte == B_42) nxt = ST_0342;
      end
      ST_KEY_K:  if (data_byte == B_65) nxt = ST_KEY_E;
      ST_KEY_E:  if (data_byte == B_79) nxt = ST_KEY_Y;
      ST_KEY_Y: begin
        if (data_byte == B_41) nxt = ST_HIT_PUB;
        if (data_byte == B_21) nxt = ST_HIT_CMP;
      end
      ST_0101:   if (data_byte == B_04) nxt = ST_010104;
      ST_010104: if (data_byte == B_20) nxt = ST_HIT_PRIV;
      ST_03:     if (data_byte == B_42) nxt = ST_0342;
      ST_Z3:     if (data_byte == B_41) nxt = ST_Z3_41;
      ST_Z3_41:  if (data_byte == B_04) nxt = ST_HIT_JAVA;
      default: ;
    endcase
  end

  always_comb begin
    fsm_out.state_nxt = nxt;
    fsm_out.java_hit  = (nxt == ST_HIT_JAVA);
    case (nxt)
      ST_HIT_PUB:  fsm_out.kind = KIND_TAG_PUB;
      ST_HIT_CMP:  fsm_out.kind = KIND_TAG_CMP;
      ST_HIT_BITS: fsm_out.kind = KIND_BITS_PUB;
      ST_HIT_PRIV: fsm_out.kind = KIND_PRIV_PREFIX;
      default:     fsm_out.kind = KIND_NONE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/krms_window.sv
// Search of the byte history for the oldest 00 00 00 20 in the key window.
`timescale 1ns / 1ps
`default_nettype none
module krms_window (
  input  wire krms_pkg::hist_t  hist,
  output logic                  found,
  output krms_pkg::back_t       back
);
  import krms_pkg::*;

  logic [WIN_N-1:0] hit;

  // hist holds the history before the current byte is shifted in, so a
  // pattern starting d back sits one index lower than after the shift
  for (genvar i = 0; i < WIN_N; i++) begin : g_cmp
    localparam int D = WIN_LO + i;
    assign hit[i] = (hist[D-2] == B_00) && (hist[D-3] == B_00) &&
                    (hist[D-4] == B_00) && (hist[D-5] == B_20);
  end

  // largest distance wins
  always_comb begin
    back = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (hit[i]) back = BACK_W'(WIN_LO + i - 4);
    end
  end

  assign found = |hit;

endmodule
`default_nettype wire

### hdl/key_record_marker_scanner_top.sv
// Key record marker scanner: one raw byte in, one marker result out per beat.
// Result valid is registered: it rises in the cycle after the input beat is taken.
// Throughput: one byte per cycle while the receiver keeps ready high; the table step and the 27 window compares
//   settle between the state/history registers and the output register.
// Reset clears scan state, byte count and output valid; history is not
//   cleared, since the window is only read once 64 bytes have been taken.
`timescale 1ns / 1ps
`default_nettype none
module key_record_marker_scanner_top (
  input  wire    clk,
  input  wire    rst_n,
  krms_in_if.sink     in_ch,
  krms_out_if.source  out_ch
);
  import krms_pkg::*;

  state_t               state_r;
  hist_t                hist_r;
  logic [SEEN_W-1:0]    seen_r;
  logic                 out_valid_r;
  kind_t                kind_r, kind_nxt;
  back_t                back_r, back_nxt;

  fsm_out_t fsm_out;
  logic     win_found;
  back_t    win_back;
  logic     accept;
  logic     full;

  krms_fsm u_fsm (
    .state     (state_r),
    .data_byte (in_ch.data_byte),
    .fsm_out   (fsm_out)
  );

  krms_window u_window (
    .hist  (hist_r),
    .found (win_found),
    .back  (win_back)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  // count includes the current byte
  assign full        = (seen_r >= SEEN_W'(HIST_LEN - 1));

  always_comb begin
    kind_nxt = fsm_out.kind;
    back_nxt = '0;
    if (fsm_out.java_hit) begin
      if (full && win_found) begin
        kind_nxt = KIND_JAVA_PRIV;
        back_nxt = win_back;
      end else begin
        kind_nxt = KIND_JAVA_NOPRIV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= fsm_out.state_nxt;
        if (seen_r < SEEN_W'(HIST_LEN)) seen_r <= seen_r + 1'b1;
      end
      if (accept) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist_r <= {hist_r[HIST_LEN-2:0], in_ch.data_byte};
      kind_r <= kind_nxt;
      back_r <= back_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.match_kind = kind_r;
  assign out_ch.priv_back  = back_r;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat produced no result");

  a_back_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_JAVA_PRIV) |->
      (back_r >= BACK_W'(BACK_MIN) && back_r <= BACK_W'(BACK_MAX)))
    else $error("private key offset outside window");

  a_back_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r != KIND_JAVA_PRIV) |-> (back_r == '0))
    else $error("nonzero offset on a result without private key");

  a_priv_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_JAVA_PRIV) |-> (seen_r == SEEN_W'(HIST_LEN)))
    else $error("private key reported before history filled");

  a_state_reachable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SPARE) && (state_r <= ST_LAST))
    else $error("scanner in unreachable state");

endmodule
`default_nettype wire

### bench/testbench.sv
// Testbench for the key record marker scanner: directed and random byte streams, scoreboarded.
`timescale 1ns / 1ps
module testbench;
  import krms_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    kind_t kind;
    back_t back;
  } marker_res_t;

  logic clk = 1'b0;
  logic rst_n;

  krms_in_if  in_ch();
  krms_out_if out_ch();

  key_record_marker_scanner_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  state_t      scan_st = ST_IDLE;
  hist_t       recent = '0;
  int unsigned taken = 0;

  marker_res_t pending_markers[$];
  byte_t       tx_bytes[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_items = 0;
  int unsigned hold_cycles = 0;
  bit          in_idle = 1'b1;
  bit          out_idle = 1'b1;

  byte_t hot_bytes[11] = '{B_00, B_01, B_03, B_04, B_20, B_21, B_41, B_42, B_65, B_6B, B_79};

  function automatic state_t next_scan(state_t st, byte_t b);
    state_t nxt;
    case (b)
      B_00:    nxt = ST_Z1;
      B_01:    nxt = ST_01;
      B_03:    nxt = ST_03;
      default: nxt = ST_IDLE;
    endcase
    case (st)
      ST_01: begin
        if (b == B_03) nxt = ST_0103;
        else if (b == B_01) nxt = ST_0101;
      end
      ST_0103: begin
        if (b == B_6B) nxt = ST_KEY_K;
        else if (b == B_42) nxt = ST_0342;
      end
      ST_KEY_K: if (b == B_65) nxt = ST_KEY_E;
      ST_KEY_E: if (b == B_79) nxt = ST_KEY_Y;
      ST_KEY_Y: begin
        if (b == B_41) nxt = ST_HIT_PUB;
        else if (b == B_21) nxt = ST_HIT_CMP;
      end
      ST_0101: begin
        if (b == B_01) nxt = ST_0101;
        else if (b == B_03) nxt = ST_0103;
        else if (b == B_04) nxt = ST_010104;
      end
      ST_010104: if (b == B_20) nxt = ST_HIT_PRIV;
      ST_03:     if (b == B_42) nxt = ST_0342;
      ST_0342:   if (b == B_00) nxt = ST_HIT_BITS;
      ST_HIT_BITS, ST_Z1: if (b == B_00) nxt = ST_Z2;
      ST_Z2:     if (b == B_00) nxt = ST_Z3;
      ST_Z3: begin
        if (b == B_00) nxt = ST_Z3;
        else if (b == B_41) nxt = ST_Z3_41;
      end
      ST_Z3_41:  if (b == B_04) nxt = ST_HIT_JAVA;
      default: ;
    endcase
    return nxt;
  endfunction

  function automatic marker_res_t predict_marker(byte_t b);
    marker_res_t r;
    int d;
    recent = {recent[HIST_LEN-2:0], b};
    if (taken < HIST_LEN) taken++;
    scan_st = next_scan(scan_st, b);
    r.kind = KIND_NONE;
    r.back = '0;
    case (scan_st)
      ST_HIT_PUB:  r.kind = KIND_TAG_PUB;
      ST_HIT_CMP:  r.kind = KIND_TAG_CMP;
      ST_HIT_BITS: r.kind = KIND_BITS_PUB;
      ST_HIT_PRIV: r.kind = KIND_PRIV_PREFIX;
      ST_HIT_JAVA: begin
        r.kind = KIND_JAVA_NOPRIV;
        // oldest 00 00 00 20 in the window wins
        if (taken >= HIST_LEN) begin
          for (d = WIN_HI; d >= WIN_LO; d--) begin
            if (r.kind == KIND_JAVA_NOPRIV && recent[d-1] == B_00 && recent[d-2] == B_00 &&
                recent[d-3] == B_00 && recent[d-4] == B_20) begin
              r.kind = KIND_JAVA_PRIV;
              r.back = back_t'(d - 4);
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic byte_t rand_byte();
    if ($urandom_range(0, 1) == 0) return hot_bytes[$urandom_range(0, 10)];
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic byte_t filler_byte(bit noisy);
    if (noisy) return rand_byte();
    return byte_t'($urandom_range(1, 255));
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("ERROR t=%0t %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // one input beat; prediction is taken when the beat is accepted
  task automatic send_byte(byte_t b);
    int gap;
    gap = in_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    pending_markers.push_back(predict_marker(b));
    sent_items++;
  endtask

  task automatic flush_bytes();
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
  endtask

  // 00 00 00 20 whose first byte sits d back from the byte after the marker;
  // d2 places a second, newer pattern; d == 0 gives a long run with no pattern
  task automatic add_java_record(int d, int d2, bit noisy);
    byte_t fill[$];
    int j;
    fill = {};
    if (d == 0) begin
      for (j = 0; j < HIST_LEN; j++) fill.push_back(filler_byte(1'b0));
    end else begin
      for (j = 0; j < d - 9; j++) fill.push_back(filler_byte(noisy));
      if (d2 >= 9 && d2 <= d - 4) begin
        j = d - d2 - 4;
        fill[j]   = B_00;
        fill[j+1] = B_00;
        fill[j+2] = B_00;
        fill[j+3] = B_20;
      end
      tx_bytes = {tx_bytes, B_00, B_00, B_00, B_20};
    end
    tx_bytes = {tx_bytes, fill, B_00, B_00, B_00, B_41, B_04};
  endtask

  task automatic maybe_break();
    int n;
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 2);
      repeat (n) void'(tx_bytes.pop_back());
      tx_bytes.push_back(rand_byte());
    end
  endtask

  task automatic test_short_history();
    tx_bytes = {B_00, B_00, B_00, B_41, B_04};
    flush_bytes();
  endtask

  task automatic test_each_marker();
    tx_bytes = {B_01, B_03, B_6B, B_65, B_79, B_41, B_01, B_03, B_6B, B_65, B_79, B_21,
                B_03, B_42, B_00, B_01, B_01, B_04, B_20, 8'hff, 8'h80, 8'h7f};
    flush_bytes();
  endtask

  task automatic test_java_window();
    int spans[5] = '{WIN_LO, WIN_HI, WIN_LO - 1, WIN_HI + 1, 50};
    int k;
    while (taken < HIST_LEN) send_byte(filler_byte(1'b0));
    for (k = 0; k < 5; k++) add_java_record(spans[k], 0, 1'b0);
    add_java_record(60, 45, 1'b0);
    add_java_record(70, 40, 1'b0);
    add_java_record(WIN_HI, WIN_LO, 1'b0);
    add_java_record(0, 0, 1'b0);
    flush_bytes();
  endtask

  task automatic test_random_stream(int unsigned n_items);
    int unsigned stop_at;
    int n;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      in_idle  = ($urandom_range(0, 7) != 0);
      out_idle = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 8);
          repeat (n) tx_bytes.push_back(rand_byte());
        end
        2: begin
          tx_bytes = {tx_bytes, B_01, B_03, B_6B, B_65, B_79, ($urandom_range(0, 1) ? B_41 : B_21)};
          maybe_break();
        end
        3: begin
          if ($urandom_range(0, 1)) tx_bytes = {tx_bytes, B_03, B_42, B_00};
          else tx_bytes = {tx_bytes, B_01, B_03, B_42, B_00};
          maybe_break();
        end
        4: begin
          tx_bytes = {tx_bytes, B_01, B_01, B_04, B_20};
          maybe_break();
        end
        5, 6, 7: begin
          add_java_record($urandom_range(9, 72), ($urandom_range(0, 3) == 0) ? $urandom_range(9, 60) : 0,
                          $urandom_range(0, 1));
          maybe_break();
        end
        default: begin
          n = $urandom_range(1, 6);
          repeat (n) tx_bytes.push_back(B_00);
          if ($urandom_range(0, 1)) tx_bytes = {tx_bytes, B_41, B_04};
        end
      endcase
      flush_bytes();
    end
    in_idle  = 1'b1;
    out_idle = 1'b1;
  endtask

  task automatic test_back_to_back();
    in_idle  = 1'b0;
    out_idle = 1'b0;
    repeat (3) add_java_record($urandom_range(WIN_LO, WIN_HI), 0, 1'b1);
    repeat (40) tx_bytes.push_back(rand_byte());
    flush_bytes();
    in_idle  = 1'b1;
    out_idle = 1'b1;
  endtask

  // receiver holds off for a long stretch while bytes keep coming
  task automatic test_output_hold();
    in_idle     = 1'b0;
    hold_cycles = 300;
    repeat (150) tx_bytes.push_back(rand_byte());
    flush_bytes();
    in_idle = 1'b1;
  endtask

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = out_idle ? $urandom_range(0, 15) : 0;
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin : check_results
    marker_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_markers.size() == 0) begin
        report_mismatch("result beat with nothing pending, kind", out_ch.match_kind, KIND_NONE);
      end else begin
        want = pending_markers.pop_front();
        if (out_ch.match_kind !== want.kind)
          report_mismatch("match_kind", out_ch.match_kind, want.kind);
        if (out_ch.priv_back !== want.back)
          report_mismatch("priv_back", out_ch.priv_back, want.back);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR timeout with %0d results pending", pending_markers.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_short_history();
    test_each_marker();
    test_java_window();
    test_random_stream(320);
    test_back_to_back();
    test_output_hold();
    in_ch.valid <= 1'b0;
    while (pending_markers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### key_record_marker_scanner_top.f
hdl/krms_pkg.sv
hdl/krms_if.sv
hdl/krms_fsm.sv
hdl/krms_window.sv
hdl/key_record_marker_scanner_top.sv
bench/testbench.sv
